// ----- rtl/adsr_pkg.sv -----
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared codes for the ADSR envelope amplitude block.
// ----------------------------------------------------------------------------
package adsr_pkg;

	typedef enum logic [1:0] {
		REG_ATTACK  = 2'd0,
		REG_DECAY   = 2'd1,
		REG_SUSTAIN = 2'd2,
		REG_RELEASE = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_ATTACK   = 3'd0,
		PH_DECAY    = 3'd1,
		PH_SUSTAIN  = 3'd2,
		PH_RELEASE  = 3'd3,
		PH_FINISHED = 3'd4
	} phase_t;

endpackage

// ----- rtl/adsr_envelope_amplitude.sv -----
// ----------------------------------------------------------------------------
// adsr_envelope_amplitude
// Linear ADSR envelope amplitude, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle and returns one result per transaction,
// which passes in order through an operand stage, a chain of
// LEVEL_FRAC_BITS+1 division cells for the attack/decay level, a multiply
// stage, a second chain of division cells for the release ramp, and an
// output register. A stalled output stalls the whole pipeline.
module adsr_envelope_amplitude
	import adsr_pkg::*;
#(
	parameter int TIME_BITS       = 24,
	parameter int LEVEL_FRAC_BITS = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [((TIME_BITS > LEVEL_FRAC_BITS+1) ? TIME_BITS : LEVEL_FRAC_BITS+1)-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [TIME_BITS-1:0]         time_now,
	input  logic                         released,
	input  logic [TIME_BITS-1:0]         release_at,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [LEVEL_FRAC_BITS:0]     amplitude,
	output logic [2:0]                   phase
);

	localparam int TB  = TIME_BITS;
	localparam int LW  = LEVEL_FRAC_BITS + 1;
	localparam int N_W = TB + LW;
	localparam logic [LW-1:0] ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
	localparam int SIDE1_W = 2 + LW + 2 + TB;
	localparam int SIDE2_W = LW + 2 + 2;

	logic [TB-1:0] attack_q, decay_q, release_q;
	logic [LW-1:0] sustain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			decay_q   <= '0;
			sustain_q <= ONE;
			release_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_ATTACK:  attack_q  <= cfg_data[TB-1:0];
				REG_DECAY:   decay_q   <= cfg_data[TB-1:0];
				REG_SUSTAIN: sustain_q <= cfg_data[LW-1:0];
				REG_RELEASE: release_q <= cfg_data[TB-1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic out_valid_q;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// operand stage
	logic          rel_act, fin;
	logic [TB-1:0] t_h, e_a, e_r, rw;
	logic [LW-1:0] s_sat;
	logic [1:0]    hph;
	logic [N_W-1:0] num1;
	logic [TB-1:0]  den1;

	always_comb begin
		rel_act = released && (time_now >= release_at);
		e_r     = time_now - release_at;
		fin     = rel_act && (e_r >= release_q);
		rw      = release_q - e_r;
		t_h     = rel_act ? release_at : time_now;
		e_a     = t_h - attack_q;
		s_sat   = (sustain_q > ONE) ? ONE : sustain_q;
		if (t_h < attack_q) begin
			hph  = PH_ATTACK[1:0];
			num1 = N_W'({t_h, {LEVEL_FRAC_BITS{1'b0}}});
			den1 = attack_q;
		end else if (e_a < decay_q) begin
			hph  = PH_DECAY[1:0];
			num1 = N_W'((ONE - s_sat) * e_a);
			den1 = decay_q;
		end else begin
			hph  = PH_SUSTAIN[1:0];
			num1 = '0;
			den1 = TB'(1);
		end
	end

	logic               v_s1;
	logic [N_W-1:0]     num1_s1;
	logic [TB-1:0]      den1_s1;
	logic [SIDE1_W-1:0] side1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num1_s1  <= num1;
			den1_s1  <= den1;
			side1_s1 <= {hph, s_sat, rel_act, fin, rw};
		end
	end

	logic               v_d1;
	logic [LW-1:0]      q1;
	logic [SIDE1_W-1:0] side1_d;

	adsr_divider #(.N_W(N_W), .D_W(TB), .Q_W(LW), .SIDE_W(SIDE1_W)) u_div_held (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s1), .in_num(num1_s1), .in_den(den1_s1), .in_side(side1_s1),
		.out_valid(v_d1), .out_quo(q1), .out_side(side1_d)
	);

	logic [1:0]    hph_d;
	logic [LW-1:0] s_d, level;
	logic          ra_d, fin_d;
	logic [TB-1:0] rw_d;

	always_comb begin
		{hph_d, s_d, ra_d, fin_d, rw_d} = side1_d;
		case (hph_d)
			PH_ATTACK[1:0]: level = q1;
			PH_DECAY[1:0]:  level = ONE - q1;
			default:        level = s_d;
		endcase
	end

	// multiply stage
	logic               v_s2;
	logic [N_W-1:0]     num2_s2;
	logic [SIDE2_W-1:0] side2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num2_s2  <= N_W'(level * rw_d);
			side2_s2 <= {level, ra_d, fin_d, hph_d};
		end
	end

	logic               v_d2;
	logic [LW-1:0]      q2;
	logic [SIDE2_W-1:0] side2_d;

	adsr_divider #(.N_W(N_W), .D_W(TB), .Q_W(LW), .SIDE_W(SIDE2_W)) u_div_rel (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s2), .in_num(num2_s2), .in_den(release_q), .in_side(side2_s2),
		.out_valid(v_d2), .out_quo(q2), .out_side(side2_d)
	);

	logic [LW-1:0] lvl_f;
	logic          ra_f, fin_f;
	logic [1:0]    hph_f;
	logic [LW-1:0] amp_n;
	logic [2:0]    ph_n;

	always_comb begin
		{lvl_f, ra_f, fin_f, hph_f} = side2_d;
		if (fin_f) begin
			amp_n = '0;
			ph_n  = PH_FINISHED;
		end else if (ra_f) begin
			amp_n = q2;
			ph_n  = PH_RELEASE;
		end else begin
			amp_n = lvl_f;
			ph_n  = {1'b0, hph_f};
		end
	end

	logic [LW-1:0] amp_q;
	logic [2:0]    phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			amp_q   <= amp_n;
			phase_q <= ph_n;
		end
	end

	assign out_valid = out_valid_q;
	assign amplitude = amp_q;
	assign phase     = phase_q;

endmodule

// ----- rtl/adsr_div_cell.sv -----
// ----------------------------------------------------------------------------
// adsr_div_cell
// One restoring-division cell: resolves one quotient bit and passes on.
// ----------------------------------------------------------------------------
module adsr_div_cell #(
	parameter int N_W    = 40,
	parameter int D_W    = 24,
	parameter int Q_W    = 16,
	parameter int SIDE_W = 8,
	parameter int BIT    = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [N_W-1:0]    in_rem,
	input  logic [D_W-1:0]    in_den,
	input  logic [Q_W-1:0]    in_quo,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [N_W-1:0]    out_rem,
	output logic [D_W-1:0]    out_den,
	output logic [Q_W-1:0]    out_quo,
	output logic [SIDE_W-1:0] out_side
);

	localparam int W = N_W + Q_W;

	logic [W-1:0] rem_x;
	logic [W-1:0] den_sh;
	logic [W-1:0] diff;
	logic         take;
	logic         valid_q;
	logic [N_W-1:0]    rem_q;
	logic [D_W-1:0]    den_q;
	logic [Q_W-1:0]    quo_q;
	logic [SIDE_W-1:0] side_q;

	assign rem_x  = {{Q_W{1'b0}}, in_rem};
	assign den_sh = {{(W-D_W){1'b0}}, in_den} << BIT;
	assign take   = rem_x >= den_sh;
	assign diff   = rem_x - den_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? diff[N_W-1:0] : in_rem;
			den_q  <= in_den;
			quo_q  <= in_quo | ({{(Q_W-1){1'b0}}, take} << BIT);
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_den   = den_q;
	assign out_quo   = quo_q;
	assign out_side  = side_q;

endmodule

// ----- rtl/adsr_divider.sv -----
// ----------------------------------------------------------------------------
// adsr_divider
// Chain of division cells, most significant quotient bit first.
// ----------------------------------------------------------------------------
module adsr_divider #(
	parameter int N_W    = 40,
	parameter int D_W    = 24,
	parameter int Q_W    = 16,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [N_W-1:0]    in_num,
	input  logic [D_W-1:0]    in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [Q_W-1:0]    out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic              v_c [Q_W+1];
	logic [N_W-1:0]    r_c [Q_W+1];
	logic [D_W-1:0]    d_c [Q_W+1];
	logic [Q_W-1:0]    q_c [Q_W+1];
	logic [SIDE_W-1:0] s_c [Q_W+1];

	assign v_c[0] = in_valid;
	assign r_c[0] = in_num;
	assign d_c[0] = in_den;
	assign q_c[0] = '0;
	assign s_c[0] = in_side;

	for (genvar i = 0; i < Q_W; i++) begin : g_cell
		adsr_div_cell #(
			.N_W(N_W), .D_W(D_W), .Q_W(Q_W), .SIDE_W(SIDE_W), .BIT(Q_W-1-i)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v_c[i]), .in_rem(r_c[i]), .in_den(d_c[i]),
			.in_quo(q_c[i]), .in_side(s_c[i]),
			.out_valid(v_c[i+1]), .out_rem(r_c[i+1]), .out_den(d_c[i+1]),
			.out_quo(q_c[i+1]), .out_side(s_c[i+1])
		);
	end

	assign out_valid = v_c[Q_W];
	assign out_quo   = q_c[Q_W];
	assign out_side  = s_c[Q_W];

endmodule

// ----- tb/sv/tb_adsr_envelope_amplitude.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adsr_envelope_amplitude
// Self-checking bench for the linear ADSR envelope amplitude block.
// ----------------------------------------------------------------------------
// Drives time/release transactions under several register settings and
// idling mixes, predicts each amplitude and phase in the bench, and compares
// every output transaction in order with the expected queue.
module tb_adsr_envelope_amplitude;
	import adsr_pkg::*;

	localparam int TB = 24;
	localparam int FB = 15;
	localparam int LAT = 2 * (FB + 1) + 3;
	localparam longint ONE = 64'd1 << FB;

	typedef struct packed {
		logic [FB:0] amp;
		phase_t      ph;
	} env_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [TB-1:0] cfg_data;
	logic          in_valid;
	logic          in_ready;
	logic [TB-1:0] time_now;
	logic          released;
	logic [TB-1:0] release_at;
	logic          out_valid;
	logic          out_ready;
	logic [FB:0]   amplitude;
	logic [2:0]    phase;

	longint atk_r, dec_r, sus_r, rel_r;
	env_t   env_q[$];
	int     errors;
	int     send_idle_pct;
	int     recv_stall_pct;
	bit     hold_off;

	adsr_envelope_amplitude dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint held_amp(longint t, output phase_t ph);
		longint s, e;
		s = (sus_r > ONE) ? ONE : sus_r;
		if (t < atk_r) begin
			ph = PH_ATTACK;
			return (t << FB) / atk_r;
		end
		e = t - atk_r;
		if (e < dec_r) begin
			ph = PH_DECAY;
			return ONE - ((ONE - s) * e) / dec_r;
		end
		ph = PH_SUSTAIN;
		return s;
	endfunction

	function automatic env_t envelope(longint t, bit rel, longint rat);
		env_t   r;
		phase_t ph, dummy;
		longint e, st;
		if (rel && t >= rat) begin
			e = t - rat;
			if (e >= rel_r) begin
				r.amp = '0;
				r.ph  = PH_FINISHED;
			end else begin
				st = held_amp(rat, dummy);
				r.amp = (FB+1)'((st * (rel_r - e)) / rel_r);
				r.ph  = PH_RELEASE;
			end
		end else begin
			r.amp = (FB+1)'(held_amp(t, ph));
			r.ph  = ph;
		end
		return r;
	endfunction

	task automatic report(string what, longint got, longint exp_v);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
	endtask

	task automatic write_reg(reg_index_t idx, longint val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[TB-1:0];
		@(posedge clk);
		case (idx)
			REG_ATTACK:  atk_r = val & 24'hFFFFFF;
			REG_DECAY:   dec_r = val & 24'hFFFFFF;
			REG_SUSTAIN: sus_r = val & 16'hFFFF;
			REG_RELEASE: rel_r = val & 24'hFFFFFF;
		endcase
	endtask

	task automatic set_envelope(longint a, longint d, longint s, longint r);
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (env_q.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (LAT + 4) @(posedge clk);
		write_reg(REG_ATTACK, a);
		write_reg(REG_DECAY, d);
		write_reg(REG_SUSTAIN, s);
		write_reg(REG_RELEASE, r);
		cfg_we <= 1'b0;
	endtask

	task automatic send(longint t, bit rel, longint rat);
		int idle;
		idle = 0;
		while ($urandom_range(99) < send_idle_pct) idle++;
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid   <= 1'b1;
		time_now   <= t[TB-1:0];
		released   <= rel;
		release_at <= rat[TB-1:0];
		do @(posedge clk); while (!in_ready);
		env_q.push_back(envelope(t & 24'hFFFFFF, rel, rat & 24'hFFFFFF));
	endtask

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		env_t x;
		if (arst_n && out_valid && out_ready) begin
			if (env_q.size() == 0) begin
				report("unexpected transaction", amplitude, 0);
			end else begin
				x = env_q.pop_front();
				if (amplitude !== x.amp) report("amplitude", amplitude, x.amp);
				if (phase !== x.ph) report("phase", phase, x.ph);
			end
		end
	end

	function automatic longint rand_time(longint span);
		case ($urandom_range(3))
			0: return $urandom_range(span);
			1: return $urandom_range(24'hFFFFFF);
			default: return $urandom_range(4 * span + 4);
		endcase
	endfunction

	task automatic random_items(int n);
		longint span, t, rat;
		bit     rel;
		span = atk_r + dec_r + rel_r + 8;
		if (span > 24'hFFFFFF) span = 24'hFFFFFF;
		repeat (n) begin
			t   = rand_time(span);
			rel = $urandom_range(1);
			rat = ($urandom_range(3) == 0) ? rand_time(span) : $urandom_range(t);
			send(t, rel, rat);
		end
	endtask

	task automatic test_defaults();
		send(0, 0, 0);
		send(24'hFFFFFF, 0, 0);
		send(5, 1, 5);
		send(24'hFFFFFF, 1, 0);
	endtask

	task automatic test_directed();
		set_envelope(100, 200, 16384, 300);
		send(0, 0, 0);
		send(50, 0, 0);
		send(99, 0, 0);
		send(100, 0, 0);
		send(250, 0, 0);
		send(299, 0, 0);
		send(300, 0, 0);
		send(150, 1, 50);
		send(200, 1, 250);
		send(400, 1, 350);
		send(649, 1, 350);
		send(650, 1, 350);
		send(10, 1, 500);
		set_envelope(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
		send(24'hFFFFFE, 0, 0);
		send(24'hFFFFFF, 0, 0);
		send(24'hFFFFFF, 1, 24'hFFFFFE);
		send(24'hFFFFFF, 1, 1);
		set_envelope(0, 0, 0, 0);
		send(7, 0, 0);
		send(7, 1, 7);
	endtask

	task automatic test_random_settings();
		longint a, d, r;
		for (int k = 0; k < 8; k++) begin
			a = ($urandom_range(3) == 0) ? 0 : $urandom_range(500);
			d = ($urandom_range(3) == 0) ? 0 : $urandom_range(500);
			r = ($urandom_range(3) == 0) ? 0 : $urandom_range(500);
			if (k == 7) begin
				a = $urandom_range(24'hFFFFFF);
				d = $urandom_range(24'hFFFFFF);
				r = $urandom_range(24'hFFFFFF);
			end
			set_envelope(a, d, $urandom_range(16'hFFFF), r);
			case (k % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				3: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			random_items(100);
		end
	endtask

	task automatic test_backpressure();
		set_envelope(64, 64, 20000, 64);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (LAT * 3) @(posedge clk);
				hold_off = 1'b0;
			end
			random_items(120);
		join
	endtask

	initial begin
		int n;
		errors = 0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		atk_r = 0; dec_r = 0; sus_r = 32768; rel_r = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; time_now = '0; released = 1'b0; release_at = '0;
		out_ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_directed();
		test_random_settings();
		test_backpressure();
		in_valid <= 1'b0;
		recv_stall_pct = 0;
		n = 0;
		while (env_q.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (LAT + 10) @(posedge clk);
		if (env_q.size() != 0) report("transactions missing", env_q.size(), 0);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
